// File: rtl/core/ftc_pkg.sv
// shared types, constants and helpers for the frame transform block
package ftc_pkg;

  localparam int CoordWidth = 32;
  localparam int RotFracBits = 14;
  localparam int RotWidth = 16;
  localparam int RowWidth = 48;

  // exact sums: point/m stage and b stage widths
  localparam int ProdWidth = CoordWidth + RotWidth;       // 48
  localparam int SumWidth = ProdWidth + 2;                // 50
  localparam int MWidth = SumWidth - RotFracBits;         // 36
  localparam int BProdWidth = MWidth + RotWidth;          // 52
  localparam int BSumWidth = BProdWidth + 2;              // 54

  localparam logic [1:0] OP_POINT = 2'd0;
  localparam logic [1:0] OP_COV = 2'd1;
  localparam logic [1:0] OP_DIAG = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [2:0] REG_ROW0 = 3'd0;
  localparam logic [2:0] REG_ROW1 = 3'd1;
  localparam logic [2:0] REG_ROW2 = 3'd2;
  localparam logic [2:0] REG_OFFX = 3'd3;
  localparam logic [2:0] REG_OFFY = 3'd4;
  localparam logic [2:0] REG_OFFZ = 3'd5;
  localparam logic [2:0] REG_ROTEN = 3'd6;

  typedef logic signed [RotWidth-1:0] rot_t;
  typedef rot_t rot_mat_t [3][3];
  typedef logic signed [CoordWidth-1:0] coord_t;

  typedef struct packed {
    logic [1:0] op;
    logic last;
    logic rot_en;
  } ctl_t;

  function automatic rot_t rot_elem(input logic [RowWidth-1:0] row, input int j);
    rot_elem = row[RotWidth*j +: RotWidth];
  endfunction

  // floor((v + half) >> frac) for a 50 bit sum
  function automatic logic signed [MWidth-1:0] round_sum(
      input logic signed [SumWidth-1:0] v);
    logic signed [SumWidth-1:0] t;
    t = v + SumWidth'(1 << (RotFracBits - 1));
    round_sum = MWidth'(t >>> RotFracBits);
  endfunction

  function automatic logic signed [BSumWidth-RotFracBits-1:0] round_bsum(
      input logic signed [BSumWidth-1:0] v);
    logic signed [BSumWidth-1:0] t;
    t = v + BSumWidth'(1 << (RotFracBits - 1));
    round_bsum = (BSumWidth-RotFracBits)'(t >>> RotFracBits);
  endfunction

endpackage

// File: rtl/core/ftc_lane.sv
// one lane: dot product of a row of rotation with a 3 vector, registered
module ftc_lane import ftc_pkg::*; (
  input  logic clk,
  input  logic en,
  input  rot_t r0,
  input  rot_t r1,
  input  rot_t r2,
  input  logic signed [MWidth-1:0] v0,
  input  logic signed [MWidth-1:0] v1,
  input  logic signed [MWidth-1:0] v2,
  output logic signed [BSumWidth-1:0] sum
);
  logic signed [BProdWidth-1:0] p0_r, p1_r, p2_r;

  // products registered, then summed
  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= BProdWidth'(r0 * v0);
      p1_r <= BProdWidth'(r1 * v1);
      p2_r <= BProdWidth'(r2 * v2);
    end
  end

  assign sum = BSumWidth'(p0_r) + BSumWidth'(p1_r) + BSumWidth'(p2_r);
endmodule

// File: rtl/core/ftc_merge.sv
// rounding, offset add, saturation and output packing
module ftc_merge import ftc_pkg::*; (
  input  ctl_t ctl,
  input  logic signed [MWidth-1:0] pt [3],
  input  logic signed [BSumWidth-1:0] bsum [6],
  input  coord_t offs [3],
  output coord_t res [6],
  output logic sat
);
  localparam int BW = BSumWidth - RotFracBits;
  localparam logic signed [BW-1:0] Hi = BW'((64'sd1 <<< (CoordWidth-1)) - 1);
  localparam logic signed [BW-1:0] Lo = -Hi - BW'(1);

  logic signed [BW-1:0] v [6];
  logic [5:0] clip;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      v[i] = '0;
      if (ctl.op == OP_COV || ctl.op == OP_DIAG) v[i] = round_bsum(bsum[i]);
    end
    if (ctl.op == OP_POINT) begin
      for (int i = 0; i < 3; i++) v[i] = BW'(pt[i]) + BW'(offs[i]);
    end
    for (int i = 0; i < 6; i++) begin
      clip[i] = (v[i] > Hi) || (v[i] < Lo);
      if (v[i] > Hi) res[i] = CoordWidth'(Hi);
      else if (v[i] < Lo) res[i] = CoordWidth'(Lo);
      else res[i] = CoordWidth'(v[i]);
    end
    sat = |clip;
  end
endmodule

// File: rtl/core/frame_transform_with_covariance.sv
// top level: frame transform of points and covariances, three stage pipeline
//  channel | direction | handshake       | payload
//  in_     | input     | valid / stall   | opcode, operand0..5, batch_end
//  out_    | output    | valid / stall   | result0..5, saturated, batch_last
//  cfg_    | input     | valid / ready   | index, data
// one item per cycle unless stalled; registered steps: first product lanes,
// m register, second product lanes (output register). the pipeline advances
// when the output register is empty or taken; in_stall follows out_stall
// while a result waits. synchronous reset clears valid bits and resets the
// config registers; input and configuration are held off during reset.
module frame_transform_with_covariance import ftc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] in_opcode,
  input  logic signed [31:0] in_operand0,
  input  logic signed [31:0] in_operand1,
  input  logic signed [31:0] in_operand2,
  input  logic signed [31:0] in_operand3,
  input  logic signed [31:0] in_operand4,
  input  logic signed [31:0] in_operand5,
  input  logic in_batch_end,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [31:0] out_result0,
  output logic signed [31:0] out_result1,
  output logic signed [31:0] out_result2,
  output logic signed [31:0] out_result3,
  output logic signed [31:0] out_result4,
  output logic signed [31:0] out_result5,
  output logic out_saturated,
  output logic out_batch_last,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [63:0] cfg_data
);
  logic [RowWidth-1:0] row_r [3];
  coord_t offs_r [3];
  logic rot_en_r;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= RowWidth'(48'h4000);
      row_r[1] <= RowWidth'(48'h4000) << 16;
      row_r[2] <= RowWidth'(48'h4000) << 32;
      offs_r[0] <= '0;
      offs_r[1] <= '0;
      offs_r[2] <= '0;
      rot_en_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW0: row_r[0] <= cfg_data[RowWidth-1:0];
        REG_ROW1: row_r[1] <= cfg_data[RowWidth-1:0];
        REG_ROW2: row_r[2] <= cfg_data[RowWidth-1:0];
        REG_OFFX: offs_r[0] <= cfg_data[CoordWidth-1:0];
        REG_OFFY: offs_r[1] <= cfg_data[CoordWidth-1:0];
        REG_OFFZ: offs_r[2] <= cfg_data[CoordWidth-1:0];
        REG_ROTEN: rot_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rot_mat_t rm;
  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        rm[i][j] = rot_elem(row_r[i], j);
  end

  // pipeline control
  logic s1_v_r, s2_v_r, s3_v_r;
  logic adv;
  assign adv = !s3_v_r || !out_stall;
  assign in_stall = !adv || !rst_n;
  logic acc;
  assign acc = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= acc;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // build the symmetric c matrix (or point vector) at input
  logic signed [MWidth-1:0] c [3][3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) c[i][j] = '0;
    if (in_opcode == OP_DIAG) begin
      c[0][0] = MWidth'(in_operand0);
      c[1][1] = MWidth'(in_operand1);
      c[2][2] = MWidth'(in_operand2);
    end else if (in_opcode == OP_COV) begin
      c[0][0] = MWidth'(in_operand0);
      c[1][0] = MWidth'(in_operand1); c[0][1] = MWidth'(in_operand1);
      c[1][1] = MWidth'(in_operand2);
      c[2][0] = MWidth'(in_operand3); c[0][2] = MWidth'(in_operand3);
      c[2][1] = MWidth'(in_operand4); c[1][2] = MWidth'(in_operand4);
      c[2][2] = MWidth'(in_operand5);
    end else begin
      // point rides in row 0
      c[0][0] = MWidth'(in_operand0);
      c[0][1] = MWidth'(in_operand1);
      c[0][2] = MWidth'(in_operand2);
    end
  end

  ctl_t ctl_in, ctl1_r, ctl2_r;
  assign ctl_in = '{op: in_opcode, last: in_batch_end, rot_en: rot_en_r};
  logic signed [MWidth-1:0] pt_raw1_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl1_r <= ctl_in;
      ctl2_r <= ctl1_r;
      for (int i = 0; i < 3; i++) pt_raw1_r[i] <= c[0][i];
    end
  end

  // stage 1 lanes: m[k][j] = sum_l c[k][l]*r[j][l]
  logic signed [BSumWidth-1:0] msum [3][3];
  logic signed [MWidth-1:0] m [3][3];
  for (genvar k = 0; k < 3; k++) begin : g_m
    for (genvar j = 0; j < 3; j++) begin : g_mj
      ftc_lane u_lane (
        .clk(clk), .en(adv),
        .r0(rm[j][0]), .r1(rm[j][1]), .r2(rm[j][2]),
        .v0(c[k][0]), .v1(c[k][1]), .v2(c[k][2]),
        .sum(msum[k][j])
      );
      assign m[k][j] = round_sum(SumWidth'(msum[k][j]));
    end
  end

  // point result computed from row 0 lanes (r[j] . p) when rotation is on, else raw point
  logic signed [MWidth-1:0] pt1 [3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      pt1[i] = ctl1_r.rot_en ? m[0][i] : pt_raw1_r[i];
  end

  logic signed [MWidth-1:0] m2_r [3][3];
  logic signed [MWidth-1:0] pt2_r [3], pt3_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      m2_r <= m;
      pt2_r <= pt1;
      pt3_r <= pt2_r;
    end
  end

  // stage 2 lanes: b[i][j] = sum_k r[i][k]*m[k][j], lower triangle
  logic signed [BSumWidth-1:0] bsum [6];
  for (genvar n = 0; n < 6; n++) begin : g_b
    localparam int I = (n == 0) ? 0 : (n < 3) ? 1 : 2;
    localparam int J = (n == 0) ? 0 : (n < 3) ? n - 1 : n - 3;
    ftc_lane u_lane (
      .clk(clk), .en(adv),
      .r0(rm[I][0]), .r1(rm[I][1]), .r2(rm[I][2]),
      .v0(m2_r[0][J]), .v1(m2_r[1][J]), .v2(m2_r[2][J]),
      .sum(bsum[n])
    );
  end

  ctl_t ctl3_r;
  always_ff @(posedge clk) begin
    if (adv) ctl3_r <= ctl2_r;
  end

  coord_t res [6];
  logic sat;
  ftc_merge u_merge (
    .ctl(ctl3_r), .pt(pt3_r), .bsum(bsum), .offs(offs_r),
    .res(res), .sat(sat)
  );

  assign out_valid = s3_v_r;
  assign out_result0 = res[0];
  assign out_result1 = res[1];
  assign out_result2 = res[2];
  assign out_result3 = res[3];
  assign out_result4 = res[4];
  assign out_result5 = res[5];
  assign out_saturated = sat;
  assign out_batch_last = ctl3_r.last;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall && s2_v_r |=> out_valid)
    else $error("pipeline item lost");
endmodule
